// ----- rtl/vot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vot_pkg
// Shared types, sizes and opcodes of the voxel occupancy table.
// ----------------------------------------------------------------------------
package vot_pkg;

    // grid size, bits per axis
    localparam int X_BITS = 5;
    localparam int Y_BITS = 5;
    localparam int Z_BITS = 5;

    // field widths
    localparam int OP_W  = 2;
    localparam int EXT_W = 8;
    localparam int CNT_W = 16;

    // flat store address: x in the high bits, z in the low bits
    localparam int ADDR_BITS = X_BITS + Y_BITS + Z_BITS;
    localparam longint unsigned STORE_DEPTH = 64'd1 << ADDR_BITS;

    // input word layout, from the lowest bit up
    localparam int IN_OP_LSB   = 0;
    localparam int IN_X_LSB    = IN_OP_LSB + OP_W;
    localparam int IN_Y_LSB    = IN_X_LSB + X_BITS;
    localparam int IN_Z_LSB    = IN_Y_LSB + Y_BITS;
    localparam int IN_EXT_LSB  = IN_Z_LSB + Z_BITS;
    localparam int IN_W        = IN_EXT_LSB + EXT_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;

    // output word layout, from the lowest bit up
    localparam int OUT_W       = 1 + EXT_W + CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;

    // opcodes; the unused code acts as a query
    localparam logic [OP_W-1:0] OP_SET     = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_MIN = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    // one store entry: occupied flag plus extruder number
    typedef struct packed {
        logic             valid;
        logic [EXT_W-1:0] ext;
    } t_entry;

    // write request into the store
    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        t_entry               data;
    } t_wr_req;

endpackage

// ----- rtl/voxel_occupancy_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_occupancy_table
// Occupancy store over a 3D voxel grid with set, set-or-min and query items.
// ----------------------------------------------------------------------------
//  channel   direction  word
//  s_axis    in         opcode, voxel_x, voxel_y, voxel_z, extruder
//  m_axis    out        was_occupied, stored_extruder, occupied_count
//
//  One item per cycle: the store is read on acceptance and written back
//  when the update stage completes; a same-voxel follower takes the
//  written entry by forwarding. A result passes the update stage register
//  and then the result register. After reset a clearing sweep writes
//  every entry; no word is accepted until it ends.
//  A stalled output holds the result register and in turn the input.
// ----------------------------------------------------------------------------
module voxel_occupancy_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // opcode, voxel_x, voxel_y, voxel_z, extruder, zero fill
    input  logic [vot_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // was_occupied, stored_extruder, occupied_count, zero fill
    output logic [vot_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import vot_pkg::*;

    logic                 clr_busy;
    t_wr_req              clr_wr;
    t_wr_req              rmw_wr;
    t_wr_req              store_wr;
    t_entry               rd_data;
    logic                 stage_free;
    logic                 accept;
    logic [OP_W-1:0]      in_op;
    logic [X_BITS-1:0]    in_x;
    logic [Y_BITS-1:0]    in_y;
    logic [Z_BITS-1:0]    in_z;
    logic [EXT_W-1:0]     in_ext;
    logic [ADDR_BITS-1:0] in_addr;
    logic                 out_occ;
    logic [EXT_W-1:0]     out_ext;
    logic [CNT_W-1:0]     out_count;

    // input word fields
    assign in_op   = i_s_axis_tdata[IN_OP_LSB +: OP_W];
    assign in_x    = i_s_axis_tdata[IN_X_LSB +: X_BITS];
    assign in_y    = i_s_axis_tdata[IN_Y_LSB +: Y_BITS];
    assign in_z    = i_s_axis_tdata[IN_Z_LSB +: Z_BITS];
    assign in_ext  = i_s_axis_tdata[IN_EXT_LSB +: EXT_W];
    assign in_addr = {in_x, in_y, in_z};

    // handshake
    assign o_s_axis_tready = !clr_busy && stage_free;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // write port owner: sweep after reset, then the update stage
    assign store_wr = clr_busy ? clr_wr : rmw_wr;

    vot_clear u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_busy  (clr_busy),
        .o_wr    (clr_wr)
    );

    vot_store u_store (
        .i_clk     (i_clk),
        .i_wr      (store_wr),
        .i_rd_en   (accept),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data)
    );

    vot_rmw u_rmw (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_op           (in_op),
        .i_addr         (in_addr),
        .i_ext          (in_ext),
        .i_rd_data      (rd_data),
        .i_out_ready    (i_m_axis_tready),
        .o_stage_free   (stage_free),
        .o_wr           (rmw_wr),
        .o_out_valid    (o_m_axis_tvalid),
        .o_was_occupied (out_occ),
        .o_stored_ext   (out_ext),
        .o_count        (out_count)
    );

    // output word
    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_ext, out_occ};

endmodule

// ----- rtl/vot_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vot_store
// Occupancy memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vot_store (
    input  logic                          i_clk,
    input  vot_pkg::t_wr_req              i_wr,
    input  logic                          i_rd_en,
    input  logic [vot_pkg::ADDR_BITS-1:0] i_rd_addr,
    output vot_pkg::t_entry               o_rd_data
);
    import vot_pkg::*;

    t_entry r_mem [STORE_DEPTH];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/vot_clear.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vot_clear
// Clearing sweep after reset: writes one empty entry per cycle over the store.
// ----------------------------------------------------------------------------
module vot_clear (
    input  logic             i_clk,
    input  logic             i_rst_n,
    output logic             o_busy,
    output vot_pkg::t_wr_req o_wr
);
    import vot_pkg::*;

    logic                 r_busy;
    logic [ADDR_BITS-1:0] r_addr;

    // sweep counter, stops after the last entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            r_addr <= r_addr + 1'b1;
            if (r_addr == {ADDR_BITS{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    // empty entry at the sweep address
    always_comb begin
        o_wr.en         = r_busy;
        o_wr.addr       = r_addr;
        o_wr.data.valid = 1'b0;
        o_wr.data.ext   = '0;
    end

    assign o_busy = r_busy;

endmodule

// ----- rtl/vot_rmw.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vot_rmw
// Read-modify-write stage: merges the old entry with the new item, writes
// back, keeps the occupied count and holds the result word.
// ----------------------------------------------------------------------------
module vot_rmw (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [vot_pkg::OP_W-1:0]      i_op,
    input  logic [vot_pkg::ADDR_BITS-1:0] i_addr,
    input  logic [vot_pkg::EXT_W-1:0]     i_ext,
    input  vot_pkg::t_entry               i_rd_data,
    input  logic                          i_out_ready,
    output logic                          o_stage_free,
    output vot_pkg::t_wr_req              o_wr,
    output logic                          o_out_valid,
    output logic                          o_was_occupied,
    output logic [vot_pkg::EXT_W-1:0]     o_stored_ext,
    output logic [vot_pkg::CNT_W-1:0]     o_count
);
    import vot_pkg::*;

    logic                 r_s1_valid;
    logic [OP_W-1:0]      r_s1_op;
    logic [ADDR_BITS-1:0] r_s1_addr;
    logic [EXT_W-1:0]     r_s1_ext;
    logic                 r_fwd_hit;
    t_entry               r_fwd_entry;
    logic [CNT_W-1:0]     r_count;
    logic                 r_out_valid;
    logic                 r_out_occ;
    logic [EXT_W-1:0]     r_out_ext;
    logic [CNT_W-1:0]     r_out_count;

    t_entry           old_entry;
    logic             occ;
    logic [EXT_W-1:0] old_ext;
    logic             is_write;
    logic [EXT_W-1:0] new_ext;
    t_entry           new_entry;
    logic             fire;
    logic [CNT_W-1:0] n_count;

    // old entry, forwarded when the previous item wrote the same voxel
    assign old_entry = r_fwd_hit ? r_fwd_entry : i_rd_data;
    assign occ       = old_entry.valid;
    assign old_ext   = occ ? old_entry.ext : '0;

    // merge
    always_comb begin
        is_write = (r_s1_op == OP_SET) || (r_s1_op == OP_SET_MIN);
        new_ext  = r_s1_ext;
        if ((r_s1_op == OP_SET_MIN) && occ && (old_ext < r_s1_ext)) begin
            new_ext = old_ext;
        end
        new_entry.valid = 1'b1;
        new_entry.ext   = new_ext;
    end

    // stage completes when the result register is free or being drained
    assign fire         = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_stage_free = !r_s1_valid || fire;

    // count update, saturating
    always_comb begin
        n_count = r_count;
        if (is_write && !occ && (r_count != {CNT_W{1'b1}})) begin
            n_count = r_count + 1'b1;
        end
    end

    // write back
    always_comb begin
        o_wr.en   = fire && is_write;
        o_wr.addr = r_s1_addr;
        o_wr.data = new_entry;
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= fire && is_write && (r_s1_addr == i_addr);
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_op     <= i_op;
            r_s1_addr   <= i_addr;
            r_s1_ext    <= i_ext;
            r_fwd_entry <= new_entry;
        end
        if (fire) begin
            r_out_occ   <= occ;
            r_out_ext   <= old_ext;
            r_out_count <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_was_occupied = r_out_occ;
    assign o_stored_ext   = r_out_ext;
    assign o_count        = r_out_count;

endmodule

// ----- dv/voxel_occupancy_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_occupancy_table_tb
// Self-checking bench for the voxel occupancy table: a short directed run over
// corner voxels, every opcode and same-voxel follow-ups, then random words
// aimed at a small set of hot voxels, with random gaps on both stream sides.
// A scoreboard keeps its own copy of the store and the occupied count and
// checks every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module voxel_occupancy_table_tb;
    import vot_pkg::*;

    // the code left unused by the block, treated as a query
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_WORDS = 450;
    localparam int HOT_VOXELS   = 12;

    typedef logic [IN_TDATA_W-1:0]  t_in_word;
    typedef logic [OUT_TDATA_W-1:0] t_out_word;

    // one predicted result word
    typedef struct {
        logic             was_occ;
        logic [EXT_W-1:0] prior_ext;
        logic [CNT_W-1:0] occ_count;
    } t_voxel_result;

    // ------------------------------------------------------------------------
    // scoreboard: shadow store, occupied count and pending results
    // ------------------------------------------------------------------------
    class voxel_scoreboard;
        t_entry          shadow_map [STORE_DEPTH];
        int unsigned     shadow_count;
        t_voxel_result   pending_results [$];
        int              errors;

        function new();
            foreach (shadow_map[i]) shadow_map[i] = '0;
            shadow_count = 0;
            errors       = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(input string what, input int got, input int want);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        // predict the result of an accepted input word and update the shadow
        function void note_input(input t_in_word w);
            logic [OP_W-1:0]      op;
            logic [EXT_W-1:0]     ext;
            logic [ADDR_BITS-1:0] addr;
            t_entry               entry;
            t_voxel_result        res;
            op    = w[IN_OP_LSB +: OP_W];
            ext   = w[IN_EXT_LSB +: EXT_W];
            addr  = {w[IN_X_LSB +: X_BITS], w[IN_Y_LSB +: Y_BITS], w[IN_Z_LSB +: Z_BITS]};
            entry = shadow_map[addr];
            res.was_occ   = entry.valid;
            res.prior_ext = entry.valid ? entry.ext : '0;
            if (op == OP_SET || op == OP_SET_MIN) begin
                // set-or-min keeps the smaller value on an occupied voxel
                if (op == OP_SET_MIN && entry.valid && entry.ext < ext)
                    ext = entry.ext;
                shadow_map[addr] = '{valid: 1'b1, ext: ext};
                if (!entry.valid && shadow_count < 65535)
                    shadow_count++;
            end
            res.occ_count = shadow_count[CNT_W-1:0];
            pending_results = {pending_results, res};
        endfunction

        // compare one accepted result word with the oldest prediction
        task check_result(input t_out_word w);
            t_voxel_result want;
            if (pending_results.size() == 0) begin
                report("unexpected word", int'(w), 0);
            end else begin
                want = pending_results.pop_front();
                if (w[0] !== want.was_occ)
                    report("was_occupied", int'(w[0]), int'(want.was_occ));
                if (w[1 +: EXT_W] !== want.prior_ext)
                    report("stored_extruder", int'(w[1 +: EXT_W]), int'(want.prior_ext));
                if (w[1 + EXT_W +: CNT_W] !== want.occ_count)
                    report("occupied_count", int'(w[1 + EXT_W +: CNT_W]),
                           int'(want.occ_count));
            end
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      s_tvalid = 1'b0;
    t_in_word  s_tdata = '0;
    logic      m_tready = 1'b0;
    logic      s_tready;
    logic      m_tvalid;
    t_out_word m_tdata;

    // set during a stretch where neither side idles
    bit        no_idle = 1'b0;

    voxel_scoreboard scb = new();

    voxel_occupancy_table u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side backpressure
    always @(negedge i_clk) begin
        m_tready = no_idle ? 1'b1 : ($urandom_range(99) >= 34);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            scb.check_result(m_tdata);
    end

    function automatic t_in_word pack_word(input logic [OP_W-1:0] op,
                                           input logic [X_BITS-1:0] x,
                                           input logic [Y_BITS-1:0] y,
                                           input logic [Z_BITS-1:0] z,
                                           input logic [EXT_W-1:0] ext);
        t_in_word w;
        w = '0;
        w[IN_OP_LSB +: OP_W]    = op;
        w[IN_X_LSB +: X_BITS]   = x;
        w[IN_Y_LSB +: Y_BITS]   = y;
        w[IN_Z_LSB +: Z_BITS]   = z;
        w[IN_EXT_LSB +: EXT_W]  = ext;
        return w;
    endfunction

    // drive one word, with an optional gap, and wait for its acceptance
    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(99) < 34) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = w;
        do @(posedge i_clk); while (!s_tready);
        scb.note_input(w);
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input int x, input int y,
                             input int z, input int ext);
        send_word(pack_word(op, x[X_BITS-1:0], y[Y_BITS-1:0], z[Z_BITS-1:0],
                            ext[EXT_W-1:0]));
    endtask

    // random word, mostly on a few hot voxels so that hits are common
    task automatic send_random(input logic [ADDR_BITS-1:0] hot [HOT_VOXELS]);
        logic [ADDR_BITS-1:0] addr;
        logic [OP_W-1:0]      op;
        logic [EXT_W-1:0]     ext;
        int                   pick;
        addr = ($urandom_range(99) < 75) ? hot[$urandom_range(HOT_VOXELS - 1)]
                                         : ADDR_BITS'($urandom);
        pick = $urandom_range(99);
        if (pick < 40)      op = OP_SET;
        else if (pick < 75) op = OP_SET_MIN;
        else if (pick < 94) op = OP_QUERY;
        else                op = OP_SPARE;
        pick = $urandom_range(9);
        if (pick == 0)      ext = '0;
        else if (pick == 1) ext = '1;
        else                ext = EXT_W'($urandom);
        send_word(pack_word(op, addr[ADDR_BITS-1 -: X_BITS],
                            addr[Z_BITS +: Y_BITS], addr[Z_BITS-1:0], ext));
    endtask

    // overall time limit
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [ADDR_BITS-1:0] hot [HOT_VOXELS];

        // reset, then the block clears its store before taking words
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty and corner voxels, all opcodes, same-voxel follow-ups
        send_item(OP_QUERY,   0,  0,  0, 0);
        send_item(OP_SET,     0,  0,  0, 0);
        send_item(OP_QUERY,   0,  0,  0, 255);
        send_item(OP_SET,    31, 31, 31, 255);
        send_item(OP_SET_MIN, 31, 31, 31, 254);
        send_item(OP_SET_MIN, 31, 31, 31, 255);
        send_item(OP_SPARE,  31, 31, 31, 0);
        send_item(OP_SET,    31, 31, 31, 7);
        send_item(OP_SET_MIN, 31, 0, 31, 200);
        send_item(OP_SET,     5, 10, 20, 8'h55);
        send_item(OP_SET_MIN, 5, 10, 20, 8'hAA);
        send_item(OP_SET,     5, 10, 20, 8'h11);
        send_item(OP_QUERY,   5, 10, 20, 0);
        send_item(OP_SET,     0, 31,  0, 8'hAA);
        send_item(OP_SET,    31,  0,  0, 8'h55);
        send_item(OP_SET_MIN, 0,  0, 31, 0);
        send_item(OP_SPARE,  16, 16, 16, 255);
        send_item(OP_QUERY,  16, 16, 16, 255);
        send_item(OP_SET_MIN, 0,  0,  0, 255);
        send_item(OP_QUERY,  31,  0, 31, 0);

        // hot voxels include the two far corners
        hot[0] = '0;
        hot[1] = '1;
        for (int i = 2; i < HOT_VOXELS; i++) hot[i] = ADDR_BITS'($urandom);

        // random part with one stretch where neither side idles
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            no_idle = (n >= 200 && n < 300);
            send_random(hot);
        end
        no_idle = 1'b0;
        @(negedge i_clk);
        s_tvalid = 1'b0;

        // drain outstanding results, then let the pipeline settle
        while (scb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (scb.errors == 0 && scb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
